// File: hw/rtl/mcc_pkg.sv
`timescale 1ns / 1ps

package mcc_pkg;

   localparam int LEVEL_W    = 24;
   localparam int CODE_W     = 14;
   localparam int DATA_W     = 7;
   localparam int STATUS_W   = 8;
   localparam int CHAN_W     = 5;
   localparam int COEF_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int SCALED_W   = 23;
   localparam int QUOT_W     = 9;
   localparam int PROD_W     = LEVEL_W + COEF_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_SELECT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MSB_CONTROLLER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIPOLAR_MODE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_COEF = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_MODE   = 3'd4;

   localparam logic [3:0]        CC_STATUS_HI   = 4'hB;
   localparam logic [DATA_W-1:0] CTL_RESET_ALL  = 7'd121;
   localparam logic [DATA_W-1:0] CTL_NOTES_OFF  = 7'd123;
   localparam logic [DATA_W:0]   LSB_OFFSET     = 8'd32;

   localparam logic [CODE_W:0]     CODE_MAX    = 15'd16383;
   localparam logic [SCALED_W-1:0] CODE_ROUND  = 23'd8191;
   localparam logic [LEVEL_W-1:0]  HALF_SCALE  = 24'd2621440;
   localparam logic [COEF_W-1:0]   COEF_ONE    = 17'h10000;
   localparam logic [PROD_W:0]     ROUND_Q16   = 42'd32768;
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 24'h7FFFFF;
   localparam logic [LEVEL_W-1:0]  LEVEL_MIN   = 24'h800000;

   typedef struct packed {
      logic [DATA_W-1:0] msb_held;
      logic [DATA_W-1:0] lsb_held;
      logic              msb_seen;
      logic              lsb_seen;
   } held_type;

   typedef struct packed {
      held_type           held;
      logic               clear;
      logic               target_we;
      logic [LEVEL_W-1:0] target;
   } midi_upd_type;

endpackage

// File: hw/rtl/mcc_target.sv
`timescale 1ns / 1ps

module mcc_target (
   input  mcc_pkg::held_type                   held,
   input  logic [mcc_pkg::CHAN_W-1:0]          channel_select,
   input  logic [mcc_pkg::DATA_W-1:0]          msb_controller,
   input  logic                                bipolar_mode,
   input  logic [mcc_pkg::STATUS_W-1:0]        status_byte,
   input  logic [mcc_pkg::DATA_W-1:0]          controller_byte,
   input  logic [mcc_pkg::DATA_W-1:0]          value_byte,
   output mcc_pkg::midi_upd_type               upd
);

   logic                                is_cc;
   logic                                chan_ok;
   logic                                cc_ok;
   logic                                msb_hit;
   logic                                lsb_hit;
   mcc_pkg::held_type                   held_new;
   logic [mcc_pkg::CODE_W-1:0]          code;
   logic [mcc_pkg::SCALED_W-1:0]        scaled;
   logic [mcc_pkg::SCALED_W-1:0]        rounded;
   logic [mcc_pkg::QUOT_W-1:0]          quot_est;
   logic [mcc_pkg::CODE_W:0]            remain;
   logic [mcc_pkg::QUOT_W-1:0]          quot;
   logic [mcc_pkg::SCALED_W-1:0]        level;

   assign is_cc   = status_byte[7:4] == mcc_pkg::CC_STATUS_HI;
   assign chan_ok = (channel_select == '0) ||
                    ({1'b0, status_byte[3:0]} == channel_select - 5'd1);
   assign cc_ok   = is_cc && chan_ok;

   assign upd.clear = cc_ok && ((controller_byte == mcc_pkg::CTL_RESET_ALL) ||
                      ((controller_byte == mcc_pkg::CTL_NOTES_OFF) && (value_byte == '0)));

   assign msb_hit = cc_ok && !upd.clear && (controller_byte == msb_controller);
   assign lsb_hit = cc_ok && !upd.clear && !msb_hit &&
                    ({1'b0, controller_byte} == {1'b0, msb_controller} + mcc_pkg::LSB_OFFSET);

   always_comb begin
      held_new = held;
      if (msb_hit) begin
         held_new.msb_held = value_byte;
         held_new.msb_seen = 1'b1;
      end
      if (lsb_hit) begin
         held_new.lsb_held = value_byte;
         held_new.lsb_seen = 1'b1;
      end
   end

   always_comb begin
      priority if (held_new.msb_seen && held_new.lsb_seen) begin
         code = {held_new.msb_held, held_new.lsb_held};
      end else if (held_new.msb_seen) begin
         code = {held_new.msb_held, 7'd0};
      end else begin
         code = {7'd0, held_new.lsb_held};
      end
   end

   // code * 10 V / 16383 in q.19 = code*320 + round(code*320 / 16383)
   assign scaled   = mcc_pkg::SCALED_W'({code, 8'd0}) + mcc_pkg::SCALED_W'({code, 6'd0});
   assign rounded  = scaled + mcc_pkg::CODE_ROUND;
   assign quot_est = rounded[mcc_pkg::SCALED_W-1:mcc_pkg::CODE_W];
   assign remain   = {1'b0, rounded[mcc_pkg::CODE_W-1:0]} +
                     (mcc_pkg::CODE_W+1)'(quot_est);
   assign quot     = quot_est + mcc_pkg::QUOT_W'(remain >= mcc_pkg::CODE_MAX);
   assign level    = scaled + mcc_pkg::SCALED_W'(quot);

   assign upd.held      = upd.clear ? '0 : held_new;
   assign upd.target_we = cc_ok && !upd.clear && (held_new.msb_seen || held_new.lsb_seen);
   assign upd.target    = {1'b0, level} - (bipolar_mode ? mcc_pkg::HALF_SCALE : '0);

endmodule

// File: hw/rtl/mcc_smooth.sv
`timescale 1ns / 1ps

module mcc_smooth (
   input  logic [mcc_pkg::LEVEL_W-1:0] target_level,
   input  logic [mcc_pkg::LEVEL_W-1:0] smoothed_level,
   input  logic [mcc_pkg::COEF_W-1:0]  coef,
   input  logic                        replace_mode,
   input  logic [mcc_pkg::LEVEL_W-1:0] bus_in,
   output logic [mcc_pkg::LEVEL_W-1:0] smoothed_next,
   output logic [mcc_pkg::LEVEL_W-1:0] cv_out
);

   logic [mcc_pkg::LEVEL_W:0]   diff;
   logic                        diff_neg;
   logic [mcc_pkg::LEVEL_W:0]   mag;
   logic [mcc_pkg::PROD_W-1:0]  prod;
   logic [mcc_pkg::PROD_W:0]    prod_rnd;
   logic [mcc_pkg::LEVEL_W-1:0] step;
   logic [mcc_pkg::LEVEL_W:0]   step_signed;
   logic [mcc_pkg::LEVEL_W:0]   level_sum;
   logic [mcc_pkg::LEVEL_W:0]   mix;

   assign diff     = {target_level[mcc_pkg::LEVEL_W-1], target_level} -
                     {smoothed_level[mcc_pkg::LEVEL_W-1], smoothed_level};
   assign diff_neg = diff[mcc_pkg::LEVEL_W];
   assign mag      = diff_neg ? -diff : diff;

   // step magnitude rounds half away from zero
   assign prod     = mag[mcc_pkg::LEVEL_W-1:0] * coef;
   assign prod_rnd = {1'b0, prod} + mcc_pkg::ROUND_Q16;
   assign step     = prod_rnd[mcc_pkg::LEVEL_W+15:16];

   assign step_signed = diff_neg ? -{1'b0, step} : {1'b0, step};
   assign level_sum   = {smoothed_level[mcc_pkg::LEVEL_W-1], smoothed_level} + step_signed;
   assign smoothed_next = level_sum[mcc_pkg::LEVEL_W-1:0];

   assign mix = {bus_in[mcc_pkg::LEVEL_W-1], bus_in} +
                {smoothed_next[mcc_pkg::LEVEL_W-1], smoothed_next};

   always_comb begin
      priority if (replace_mode) begin
         cv_out = smoothed_next;
      end else if (mix[mcc_pkg::LEVEL_W] != mix[mcc_pkg::LEVEL_W-1]) begin
         cv_out = mix[mcc_pkg::LEVEL_W] ? mcc_pkg::LEVEL_MIN : mcc_pkg::LEVEL_MAX;
      end else begin
         cv_out = mix[mcc_pkg::LEVEL_W-1:0];
      end
   end

endmodule

// File: hw/rtl/midi_14bit_cc_to_cv_core.sv
// a tick beat is registered in the work stage, then in the result register
// throughput: one beat per cycle, midi and tick in any mix, unless a tick is held
// the held bytes, target and smoothed level form a registered loop in the work stage
// rsp stall holds a tick in the work stage only while the result register is full
// synchronous reset: clears valids and converter state, restores defaults, no sweep
`timescale 1ns / 1ps

module midi_14bit_cc_to_cv_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [mcc_pkg::STATUS_W-1:0]         req_status_byte,
   input  logic [mcc_pkg::DATA_W-1:0]           req_controller_byte,
   input  logic [mcc_pkg::DATA_W-1:0]           req_value_byte,
   input  logic signed [mcc_pkg::LEVEL_W-1:0]   req_bus_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mcc_pkg::LEVEL_W-1:0]   rsp_cv_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mcc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mcc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic [mcc_pkg::CHAN_W-1:0]    channel_select_ff;
   logic [mcc_pkg::DATA_W-1:0]    msb_controller_ff;
   logic                          bipolar_mode_ff;
   logic [mcc_pkg::COEF_W-1:0]    coef_ff;
   logic                          replace_mode_ff;

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic                          s1_action_ff;
   logic [mcc_pkg::STATUS_W-1:0]  s1_status_ff;
   logic [mcc_pkg::DATA_W-1:0]    s1_ctl_ff;
   logic [mcc_pkg::DATA_W-1:0]    s1_val_ff;
   logic [mcc_pkg::LEVEL_W-1:0]   s1_bus_ff;

   mcc_pkg::held_type             held_ff;
   mcc_pkg::held_type             held_in;
   logic [mcc_pkg::LEVEL_W-1:0]   target_ff;
   logic [mcc_pkg::LEVEL_W-1:0]   target_in;
   logic [mcc_pkg::LEVEL_W-1:0]   smoothed_ff;
   logic [mcc_pkg::LEVEL_W-1:0]   smoothed_in;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [mcc_pkg::LEVEL_W-1:0]   rsp_cv_ff;

   logic                          req_accept;
   logic                          csr_write;
   logic                          out_free;
   logic                          s1_go;
   logic                          tick_go;
   logic                          midi_go;
   mcc_pkg::midi_upd_type         upd;
   logic [mcc_pkg::LEVEL_W-1:0]   smoothed_next;
   logic [mcc_pkg::LEVEL_W-1:0]   cv_next;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_go      = s1_valid_ff && (!s1_action_ff || out_free);
   assign tick_go    = s1_go && s1_action_ff;
   assign midi_go    = s1_go && !s1_action_ff;
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = tick_go || (rsp_valid_ff && rsp_stall);

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cv_out = rsp_cv_ff;

   mcc_target u_target (
      .held            (held_ff),
      .channel_select  (channel_select_ff),
      .msb_controller  (msb_controller_ff),
      .bipolar_mode    (bipolar_mode_ff),
      .status_byte     (s1_status_ff),
      .controller_byte (s1_ctl_ff),
      .value_byte      (s1_val_ff),
      .upd             (upd)
   );

   mcc_smooth u_smooth (
      .target_level   (target_ff),
      .smoothed_level (smoothed_ff),
      .coef           (coef_ff),
      .replace_mode   (replace_mode_ff),
      .bus_in         (s1_bus_ff),
      .smoothed_next  (smoothed_next),
      .cv_out         (cv_next)
   );

   always_comb begin
      held_in     = held_ff;
      target_in   = target_ff;
      smoothed_in = smoothed_ff;
      if (midi_go) begin
         held_in = upd.held;
         if (upd.clear) begin
            target_in   = '0;
            smoothed_in = '0;
         end else if (upd.target_we) begin
            target_in = upd.target;
         end
      end
      if (tick_go) begin
         smoothed_in = smoothed_next;
      end
   end

   // config registers, coefficient clamped to unity on write
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_select_ff <= '0;
         msb_controller_ff <= 7'd1;
         bipolar_mode_ff   <= 1'b0;
         coef_ff           <= mcc_pkg::COEF_ONE;
         replace_mode_ff   <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            mcc_pkg::CSR_CHANNEL_SELECT: begin
               channel_select_ff <= csr_wdata[mcc_pkg::CHAN_W-1:0];
            end
            mcc_pkg::CSR_MSB_CONTROLLER: begin
               msb_controller_ff <= csr_wdata[mcc_pkg::DATA_W-1:0];
            end
            mcc_pkg::CSR_BIPOLAR_MODE: begin
               bipolar_mode_ff <= csr_wdata[0];
            end
            mcc_pkg::CSR_SMOOTHING_COEF: begin
               coef_ff <= csr_wdata[mcc_pkg::COEF_W-1] ? mcc_pkg::COEF_ONE
                                                       : csr_wdata[mcc_pkg::COEF_W-1:0];
            end
            mcc_pkg::CSR_REPLACE_MODE: begin
               replace_mode_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
         target_ff    <= '0;
         smoothed_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         target_ff    <= target_in;
         smoothed_ff  <= smoothed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= req_action;
         s1_status_ff <= req_status_byte;
         s1_ctl_ff    <= req_controller_byte;
         s1_val_ff    <= req_value_byte;
         s1_bus_ff    <= req_bus_in;
      end
      if (tick_go) begin
         rsp_cv_ff <= cv_next;
      end
   end

endmodule

// File: hw/rtl/mcc_checker.sv
`timescale 1ns / 1ps

module mcc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_action,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [mcc_pkg::LEVEL_W-1:0]  rsp_cv_out,
   input logic                                csr_ready
);

   logic tick_beat;

   assign tick_beat = req_valid && !req_stall && req_action;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_cv_out))
      else $error("rsp data changed while stalled");

   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("req stalled with result side free");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && csr_ready)
      else $error("result pending after reset");

   a_tick_only: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(rsp_valid) && !$past(tick_beat) |=> !rsp_valid)
      else $error("result without a tick beat");

endmodule

bind midi_14bit_cc_to_cv_core mcc_checker u_mcc_checker (.*);

// File: bench/tb_midi_14bit_cc_to_cv_core.sv
`timescale 1ns / 1ps

module tb_midi_14bit_cc_to_cv_core;

   localparam longint FULL_SCALE   = 5242880;
   localparam longint HALF_LEVEL   = 2621440;
   localparam longint CODE_TOP     = 16383;
   localparam longint UNITY_COEF   = 65536;
   localparam longint SAT_HI       = 8388607;
   localparam longint SAT_LO       = -8388608;
   localparam int     HOLD_CYCLES  = 300;
   localparam int     PHASE_BEATS  = 250;
   localparam int     RANDOM_PHASES = 8;

   typedef struct {
      logic                               action;
      logic [mcc_pkg::STATUS_W-1:0]       status;
      logic [mcc_pkg::DATA_W-1:0]         ctl;
      logic [mcc_pkg::DATA_W-1:0]         val;
      logic signed [mcc_pkg::LEVEL_W-1:0] bus;
   } midi_beat_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_action = 1'b0;
   logic [mcc_pkg::STATUS_W-1:0]         req_status_byte = '0;
   logic [mcc_pkg::DATA_W-1:0]           req_controller_byte = '0;
   logic [mcc_pkg::DATA_W-1:0]           req_value_byte = '0;
   logic signed [mcc_pkg::LEVEL_W-1:0]   req_bus_in = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [mcc_pkg::LEVEL_W-1:0]   rsp_cv_out;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [mcc_pkg::CSR_IDX_W-1:0]        csr_index = '0;
   logic [mcc_pkg::CSR_DATA_W-1:0]       csr_wdata = '0;

   // register shadow
   logic [mcc_pkg::CHAN_W-1:0]           chan_sel = '0;
   logic [mcc_pkg::DATA_W-1:0]           msb_ctl = 7'd1;
   logic                                 bipolar = 1'b0;
   logic [mcc_pkg::COEF_W-1:0]           coef = 17'h10000;
   logic                                 replace = 1'b1;

   // converter state
   logic [mcc_pkg::DATA_W-1:0]           msb_held = '0;
   logic [mcc_pkg::DATA_W-1:0]           lsb_held = '0;
   logic                                 msb_seen = 1'b0;
   logic                                 lsb_seen = 1'b0;
   logic signed [mcc_pkg::LEVEL_W-1:0]   target_lvl = '0;
   logic signed [mcc_pkg::LEVEL_W-1:0]   smooth_lvl = '0;

   midi_beat_type                        pending_beats[$];
   midi_beat_type                        cur_beat;
   logic signed [mcc_pkg::LEVEL_W-1:0]   cv_expected[$];
   int                                   error_count = 0;
   int                                   send_idle_pct = 0;
   int                                   stall_pct = 0;
   logic                                 pressure_on = 1'b0;
   int                                   hold_count = 0;

   midi_14bit_cc_to_cv_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_status_byte     (req_status_byte),
      .req_controller_byte (req_controller_byte),
      .req_value_byte      (req_value_byte),
      .req_bus_in          (req_bus_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cv_out          (rsp_cv_out),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_midi_14bit_cc_to_cv_core: done, errors");
      $finish;
   end

   function automatic void clear_converter();
      msb_held   = '0;
      lsb_held   = '0;
      msb_seen   = 1'b0;
      lsb_seen   = 1'b0;
      target_lvl = '0;
      smooth_lvl = '0;
   endfunction

   function automatic void apply_midi(logic [mcc_pkg::STATUS_W-1:0] status,
                                      logic [mcc_pkg::DATA_W-1:0] ctl,
                                      logic [mcc_pkg::DATA_W-1:0] val);
      longint code;
      longint lvl;
      if (status[7:4] != mcc_pkg::CC_STATUS_HI) return;
      if (chan_sel != 0 && int'(status[3:0]) != int'(chan_sel) - 1) return;
      if (ctl == mcc_pkg::CTL_RESET_ALL || (ctl == mcc_pkg::CTL_NOTES_OFF && val == 0)) begin
         clear_converter();
         return;
      end
      if (ctl == msb_ctl) begin
         msb_held = val;
         msb_seen = 1'b1;
      end else if (int'(ctl) == int'(msb_ctl) + 32) begin
         lsb_held = val;
         lsb_seen = 1'b1;
      end
      if (!msb_seen && !lsb_seen) return;
      if (msb_seen && lsb_seen) code = longint'(msb_held) * 128 + longint'(lsb_held);
      else if (msb_seen) code = longint'(msb_held) * 128;
      else code = longint'(lsb_held);
      lvl = (code * FULL_SCALE + CODE_TOP / 2) / CODE_TOP;
      if (bipolar) lvl = lvl - HALF_LEVEL;
      target_lvl = lvl[mcc_pkg::LEVEL_W-1:0];
   endfunction

   function automatic logic signed [mcc_pkg::LEVEL_W-1:0] smooth_and_mix(
      logic signed [mcc_pkg::LEVEL_W-1:0] bus);
      longint coef_eff;
      longint diff;
      longint mag;
      longint stepv;
      longint sum;
      coef_eff = (longint'(coef) > UNITY_COEF) ? UNITY_COEF : longint'(coef);
      diff = longint'(target_lvl) - longint'(smooth_lvl);
      mag = ((diff < 0) ? -diff : diff) * coef_eff;
      stepv = (mag + 32768) >>> 16;
      if (diff < 0) stepv = -stepv;
      sum = longint'(smooth_lvl) + stepv;
      smooth_lvl = sum[mcc_pkg::LEVEL_W-1:0];
      if (replace) return smooth_lvl;
      sum = longint'(bus) + longint'(smooth_lvl);
      if (sum > SAT_HI) sum = SAT_HI;
      if (sum < SAT_LO) sum = SAT_LO;
      return sum[mcc_pkg::LEVEL_W-1:0];
   endfunction

   function automatic void predict_beat(midi_beat_type b);
      if (b.action == 1'b0) apply_midi(b.status, b.ctl, b.val);
      else cv_expected.push_back(smooth_and_mix(b.bus));
   endfunction

   function automatic void add_beat(logic action, logic [mcc_pkg::STATUS_W-1:0] status,
                                    logic [mcc_pkg::DATA_W-1:0] ctl,
                                    logic [mcc_pkg::DATA_W-1:0] val,
                                    logic signed [mcc_pkg::LEVEL_W-1:0] bus);
      midi_beat_type b;
      b.action = action;
      b.status = status;
      b.ctl    = ctl;
      b.val    = val;
      b.bus    = bus;
      pending_beats.push_back(b);
   endfunction

   function automatic logic [mcc_pkg::DATA_W-1:0] rand_data7();
      int r;
      r = $urandom_range(7);
      if (r == 0) return 7'd0;
      if (r == 1) return 7'd127;
      return mcc_pkg::DATA_W'($urandom_range(127));
   endfunction

   function automatic logic signed [mcc_pkg::LEVEL_W-1:0] rand_bus();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 24'sh7FFFFF;
      if (r == 1) return 24'sh800000;
      if (r == 2) return '0;
      if (r == 3) return mcc_pkg::LEVEL_W'($signed($urandom_range(2000)) - 1000);
      return mcc_pkg::LEVEL_W'($urandom);
   endfunction

   function automatic void add_random_beat();
      int n;
      logic [3:0] chan;
      logic [mcc_pkg::DATA_W-1:0] ctl;
      n = $urandom_range(99);
      if (chan_sel >= 1 && chan_sel <= 16 && $urandom_range(9) != 0) chan = 4'(chan_sel - 1);
      else chan = 4'($urandom_range(15));
      if (n < 45) begin
         add_beat(1'b1, mcc_pkg::STATUS_W'($urandom_range(255)), rand_data7(), rand_data7(),
                  rand_bus());
      end else if (n < 85) begin
         ctl = $urandom_range(1) ? msb_ctl : mcc_pkg::DATA_W'(msb_ctl + mcc_pkg::LSB_OFFSET);
         add_beat(1'b0, {mcc_pkg::CC_STATUS_HI, chan}, ctl, rand_data7(), '0);
      end else if (n < 88) begin
         ctl = $urandom_range(1) ? mcc_pkg::CTL_RESET_ALL : mcc_pkg::CTL_NOTES_OFF;
         add_beat(1'b0, {mcc_pkg::CC_STATUS_HI, chan}, ctl,
                  $urandom_range(1) ? 7'd0 : rand_data7(), rand_bus());
      end else begin
         add_beat(1'b0, mcc_pkg::STATUS_W'($urandom_range(255)),
                  mcc_pkg::DATA_W'($urandom_range(127)),
                  mcc_pkg::DATA_W'($urandom_range(127)), rand_bus());
      end
   endfunction

   task automatic write_reg(logic [mcc_pkg::CSR_IDX_W-1:0] idx, int unsigned data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[mcc_pkg::CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mcc_pkg::CSR_CHANNEL_SELECT: chan_sel = data[mcc_pkg::CHAN_W-1:0];
         mcc_pkg::CSR_MSB_CONTROLLER: msb_ctl  = data[mcc_pkg::DATA_W-1:0];
         mcc_pkg::CSR_BIPOLAR_MODE:   bipolar  = data[0];
         mcc_pkg::CSR_SMOOTHING_COEF: coef     = data[mcc_pkg::COEF_W-1:0];
         mcc_pkg::CSR_REPLACE_MODE:   replace  = data[0];
         default: ;
      endcase
   endtask

   task automatic write_all(int unsigned ch, int unsigned msb, int unsigned bip,
                            int unsigned cf, int unsigned rep);
      write_reg(mcc_pkg::CSR_CHANNEL_SELECT, ch);
      write_reg(mcc_pkg::CSR_MSB_CONTROLLER, msb);
      write_reg(mcc_pkg::CSR_BIPOLAR_MODE, bip);
      write_reg(mcc_pkg::CSR_SMOOTHING_COEF, cf);
      write_reg(mcc_pkg::CSR_REPLACE_MODE, rep);
   endtask

   // midi beats leave no result, so allow the pipeline to settle after the last one
   task automatic drain_phase();
      while (pending_beats.size() != 0 || req_valid || cv_expected.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic random_phase(int k);
      int r;
      int unsigned ch;
      int unsigned cf;
      if (k == 0) begin
         write_all(0, 0, 0, 1, 0);
      end else if (k == 1) begin
         write_all(16, 127, 1, 65536, 1);
      end else begin
         r = $urandom_range(9);
         if (r < 3) ch = 0;
         else if (r < 9) ch = $urandom_range(1, 16);
         else ch = $urandom_range(17, 31);
         r = $urandom_range(5);
         if (r == 0) cf = 65536;
         else if (r == 1) cf = $urandom_range(1, 256);
         else if (r == 2) cf = $urandom_range(0, 131071);
         else cf = $urandom_range(1024, 65536);
         write_all(ch, $urandom_range(127), $urandom_range(1), cf, $urandom_range(1));
      end
      case (k % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 56; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 56; end
         default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      if (k == 4) pressure_on = 1'b1;
      repeat (PHASE_BEATS) add_random_beat();
      drain_phase();
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_beat(cur_beat);
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_beat = pending_beats.pop_front();
               req_action          <= cur_beat.action;
               req_status_byte     <= cur_beat.status;
               req_controller_byte <= cur_beat.ctl;
               req_value_byte      <= cur_beat.val;
               req_bus_in          <= cur_beat.bus;
               req_valid           <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver, with one long hold-off once pressure is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (pressure_on && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cv_expected.size() == 0) begin
            error_count = error_count + 1;
            if (error_count <= 10)
               $display("unexpected cv_out beat: got %0d", rsp_cv_out);
         end else if (rsp_cv_out !== cv_expected[0]) begin
            error_count = error_count + 1;
            if (error_count <= 10)
               $display("cv_out mismatch: expected %0d, got %0d", cv_expected[0], rsp_cv_out);
            void'(cv_expected.pop_front());
         end else begin
            void'(cv_expected.pop_front());
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // register defaults: unipolar, no smoothing, replace
      add_beat(1'b1, 8'h00, 7'd0, 7'd0, 24'sh123456);
      add_beat(1'b0, 8'hB0, 7'd1, 7'd127, '0);
      add_beat(1'b1, 8'h00, 7'd0, 7'd0, '0);
      add_beat(1'b0, 8'hB5, 7'd33, 7'd127, '0);
      add_beat(1'b1, 8'hFF, 7'd127, 7'd127, 24'sh7FFFFF);
      add_beat(1'b0, 8'h90, 7'd1, 7'd0, '0);
      add_beat(1'b0, 8'hB0, mcc_pkg::CTL_NOTES_OFF, 7'd5, '0);
      add_beat(1'b1, 8'h00, 7'd0, 7'd0, '0);
      add_beat(1'b0, 8'hB0, mcc_pkg::CTL_NOTES_OFF, 7'd0, '0);
      add_beat(1'b0, 8'hB2, 7'd33, 7'd1, '0);
      add_beat(1'b1, 8'h00, 7'd0, 7'd0, '0);
      add_beat(1'b0, 8'hBC, mcc_pkg::CTL_RESET_ALL, 7'd64, '0);
      add_beat(1'b1, 8'h00, 7'd0, 7'd0, '0);
      drain_phase();

      // channel 16 only, lsb out of range, bipolar, frozen smoother, add
      write_all(16, 127, 1, 0, 0);
      add_beat(1'b0, 8'hBF, 7'd127, 7'd127, '0);
      add_beat(1'b0, 8'hB3, 7'd127, 7'd0, '0);
      add_beat(1'b1, 8'h00, 7'd0, 7'd0, 24'sh7FFFFF);
      drain_phase();

      // oversized coefficient acts as unity
      write_reg(mcc_pkg::CSR_SMOOTHING_COEF, 131071);
      add_beat(1'b1, 8'h00, 7'd0, 7'd0, 24'sh7FFFFF);
      add_beat(1'b1, 8'h00, 7'd0, 7'd0, 24'sh800000);
      drain_phase();

      // channel select that matches nothing
      write_reg(mcc_pkg::CSR_CHANNEL_SELECT, 31);
      write_reg(mcc_pkg::CSR_SMOOTHING_COEF, 32768);
      add_beat(1'b0, 8'hBF, mcc_pkg::CTL_RESET_ALL, 7'd0, '0);
      add_beat(1'b1, 8'h00, 7'd0, 7'd0, '0);
      add_beat(1'b1, 8'h00, 7'd0, 7'd0, 24'sh400000);
      drain_phase();

      for (int k = 0; k < RANDOM_PHASES; k++) random_phase(k);

      repeat (10) @(posedge clock);
      if (error_count == 0 && cv_expected.size() == 0)
         $display("tb_midi_14bit_cc_to_cv_core: done, clean");
      else
         $display("tb_midi_14bit_cc_to_cv_core: done, errors");
      $finish;
   end

endmodule

// File: midi_14bit_cc_to_cv_core.f
hw/rtl/mcc_pkg.sv
hw/rtl/mcc_target.sv
hw/rtl/mcc_smooth.sv
hw/rtl/midi_14bit_cc_to_cv_core.sv
hw/rtl/mcc_checker.sv
bench/tb_midi_14bit_cc_to_cv_core.sv
